>>> rtl/core/pctd_pkg.sv
// types, constants and helpers shared by the prefix-code table decoder
`default_nettype none

package pctd_pkg;

  localparam int CODE_W        = 16;
  localparam int LEN_W         = 5;
  localparam int SYM_W         = 8;
  localparam int OP_W          = 2;
  localparam int STATUS_W      = 2;
  localparam int IN_DATA_W     = 32;
  localparam int OUT_DATA_W    = 8;
  localparam int TBL_ENTRIES_DEF = 256;
  localparam int MAX_CODE_LEN  = 16;
  localparam int LEN_LIMIT     = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  // input tdata bit positions
  localparam int SYM_LSB  = 0;
  localparam int CODE_LSB = SYM_LSB + SYM_W;
  localparam int LEN_LSB  = CODE_LSB + CODE_W;
  localparam int BIT_POS  = LEN_LSB + LEN_W;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_DECODE = 2'd2
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_NONE = 2'd0,
    ST_EMIT = 2'd1,
    ST_LONG = 2'd2,
    ST_FULL = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_SCAN,
    CS_WAIT
  } ctrl_state_e;

  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } tbl_entry_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
    logic slot_free;
  } dp_sts_t;

  function automatic logic [CODE_W-1:0] low_mask(input logic [LEN_W-1:0] len);
    logic [CODE_W-1:0] m;
    if (len >= LEN_W'(CODE_W)) begin
      m = '1;
    end else begin
      m = (CODE_W'(1) << len) - CODE_W'(1);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/prefix_code_table_decoder.sv
// top level of the prefix-code table decoder
//
// input stream: one transfer per command. tuser carries the opcode (clear table,
// load codeword, decode one bit); tdata carries the codeword entry and the code bit.
// output stream: exactly one transfer per accepted command. tuser carries the
// status (nothing, symbol emitted, prefix too long, table full), tdata the symbol,
// zero unless a symbol was emitted.
// flow: one command at a time. a clear or an ignored command goes from accept to the
// commit with no table walk; a load or decode walks the codeword table through
// its single read port, one entry per cycle, until an entry matches or every filled
// entry has been read, and commits after that.
// the result is written into an output register at the commit, and the next
// command is taken while it waits there.
// stall: if the receiver holds tready low, the following command is processed up to
// its commit and then waits until the output register is free; nothing is dropped.
// reset: table emptied (fill count cleared, table memory left as is), prefix cleared,
// output stream empty, ready high in the first cycle after reset.
`default_nettype none

module prefix_code_table_decoder
  import pctd_pkg::*;
#(
  parameter int TABLE_ENTRIES = TBL_ENTRIES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // entry_symbol[7:0], entry_code[23:8], entry_length[28:24], code_bit[29], zero[31:30]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // opcode[1:0]
  input  wire logic [OP_W-1:0]       s_axis_tuser_i,
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // symbol[7:0]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o,
  // status[1:0]
  output logic [STATUS_W-1:0]        m_axis_tuser_o
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  pctd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .sts_i     (dp_sts),
    .cmd_o     (dp_cmd)
  );

  pctd_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .sts_o      (dp_sts),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o)
  );

  // a result is only committed into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.commit |-> dp_sts.slot_free)
    else $error("commit while output register occupied");

  // a committed result shows up on the output channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.commit |=> m_axis_tvalid_o)
    else $error("committed result not presented");

  // no new command while the previous one is still in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.accept |=> !s_axis_tready_o)
    else $error("command accepted while busy");

  // symbol is zero unless a symbol was emitted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != ST_EMIT)) |-> (m_axis_tdata_o == '0))
    else $error("non-zero symbol without emit status");

endmodule

`default_nettype wire

>>> rtl/core/pctd_ctrl.sv
// controller state machine of the prefix-code table decoder
`default_nettype none

module pctd_ctrl
  import pctd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    s_valid_i,
  output logic         s_ready_o,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      CS_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = sts_i.need_scan ? CS_SCAN : CS_WAIT;
        end
      end
      CS_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = CS_WAIT;
        end
      end
      CS_WAIT: begin
        // commit only once the output register can take the result
        if (sts_i.slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = CS_IDLE;
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/pctd_dp.sv
// datapath of the prefix-code table decoder: table memory, scan, prefix and output register
`default_nettype none

module pctd_dp
  import pctd_pkg::*;
#(
  parameter int TABLE_ENTRIES = TBL_ENTRIES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire dp_cmd_t               cmd_i,
  output dp_sts_t                    sts_o,
  input  wire logic [IN_DATA_W-1:0]  s_tdata_i,
  input  wire logic [OP_W-1:0]       s_tuser_i,
  input  wire logic                  m_tready_i,
  output logic                       m_tvalid_o,
  output logic [OUT_DATA_W-1:0]      m_tdata_o,
  output logic [STATUS_W-1:0]        m_tuser_o
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  // incoming fields
  logic [OP_W-1:0]   in_op;
  logic [SYM_W-1:0]  in_sym;
  logic [CODE_W-1:0] in_code;
  logic [LEN_W-1:0]  in_len;
  logic              in_bit;
  logic              in_len_ok;
  logic [LEN_W-1:0]  dec_len;
  logic [CODE_W-1:0] dec_bits;

  // item registers
  logic [OP_W-1:0]   op_q;
  logic [SYM_W-1:0]  sym_q;
  logic              load_ok_q;
  logic [CODE_W-1:0] key_code_q;
  logic [LEN_W-1:0]  key_len_q;

  // table and scan
  tbl_entry_t        tbl_mem [TABLE_ENTRIES];
  tbl_entry_t        rd_q;
  tbl_entry_t        wdata;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  waddr;
  logic              mem_we;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  issue_idx_q;
  logic              issue_more;
  logic              cmp_valid_q;
  logic [IDX_W-1:0]  cmp_idx_q;
  logic              match;
  logic              scan_done;
  logic              hit_q;
  logic [IDX_W-1:0]  hit_idx_q;
  logic [SYM_W-1:0]  hit_sym_q;
  logic              full;

  // prefix
  logic [CODE_W-1:0] prefix_bits_q;
  logic [LEN_W-1:0]  prefix_len_q;

  // result and output register
  status_e           res_status;
  logic [SYM_W-1:0]  res_sym;
  logic              out_valid_q;
  status_e           out_status_q;
  logic [SYM_W-1:0]  out_sym_q;
  logic              slot_free;

  assign in_op    = s_tuser_i;
  assign in_sym   = s_tdata_i[SYM_LSB +: SYM_W];
  assign in_code  = s_tdata_i[CODE_LSB +: CODE_W];
  assign in_len   = s_tdata_i[LEN_LSB +: LEN_W];
  assign in_bit   = s_tdata_i[BIT_POS];
  assign in_len_ok = (in_len != '0) && (in_len <= LEN_W'(LEN_LIMIT));

  assign dec_len  = prefix_len_q + LEN_W'(1);
  assign dec_bits = {prefix_bits_q[CODE_W-2:0], in_bit} & low_mask(dec_len);

  assign issue_more = issue_idx_q < count_q;
  assign rd_addr    = issue_more ? issue_idx_q[IDX_W-1:0] : '0;
  assign match      = cmp_valid_q && (rd_q.len == key_len_q) && (rd_q.code == key_code_q);
  assign scan_done  = match || (!cmp_valid_q && !issue_more);
  assign full       = count_q == CNT_W'(TABLE_ENTRIES);
  assign slot_free  = !out_valid_q || m_tready_i;

  assign sts_o.need_scan = ((in_op == OP_LOAD) && in_len_ok) || (in_op == OP_DECODE);
  assign sts_o.scan_done = scan_done;
  assign sts_o.slot_free = slot_free;

  always_comb begin
    res_status = ST_NONE;
    res_sym    = '0;
    case (op_q)
      OP_LOAD: begin
        if (load_ok_q && !hit_q && full) begin
          res_status = ST_FULL;
        end
      end
      OP_DECODE: begin
        if (hit_q) begin
          res_status = ST_EMIT;
          res_sym    = hit_sym_q;
        end else if (key_len_q >= LEN_W'(LEN_LIMIT)) begin
          res_status = ST_LONG;
        end
      end
      default: begin
        res_status = ST_NONE;
      end
    endcase
  end

  // a load overwrites the matching entry, or appends at the fill count if the table is not full
  assign mem_we     = cmd_i.commit && load_ok_q && (hit_q || !full);
  assign waddr      = hit_q ? hit_idx_q : count_q[IDX_W-1:0];
  assign wdata.sym  = sym_q;
  assign wdata.len  = key_len_q;
  assign wdata.code = key_code_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tbl_mem[waddr] <= wdata;
    end
    rd_q <= tbl_mem[rd_addr];
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q      <= in_op;
      sym_q     <= in_sym;
      load_ok_q <= (in_op == OP_LOAD) && in_len_ok;
      if (in_op == OP_DECODE) begin
        key_code_q <= dec_bits;
        key_len_q  <= dec_len;
      end else begin
        key_code_q <= in_code & low_mask(in_len);
        key_len_q  <= in_len;
      end
    end
    if (cmd_i.scan) begin
      cmp_idx_q <= issue_idx_q[IDX_W-1:0];
      if (scan_done) begin
        hit_idx_q <= cmp_idx_q;
        hit_sym_q <= rd_q.sym;
      end
    end
    if (cmd_i.commit) begin
      out_status_q <= res_status;
      out_sym_q    <= res_sym;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      issue_idx_q   <= '0;
      cmp_valid_q   <= 1'b0;
      hit_q         <= 1'b0;
      prefix_bits_q <= '0;
      prefix_len_q  <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        issue_idx_q <= '0;
        cmp_valid_q <= 1'b0;
        hit_q       <= 1'b0;
      end
      if (cmd_i.scan) begin
        cmp_valid_q <= issue_more;
        if (issue_more) begin
          issue_idx_q <= issue_idx_q + CNT_W'(1);
        end
        if (scan_done) begin
          hit_q <= match;
        end
      end
      if (cmd_i.commit) begin
        case (op_q)
          OP_CLEAR: begin
            count_q       <= '0;
            prefix_bits_q <= '0;
            prefix_len_q  <= '0;
          end
          OP_LOAD: begin
            if (load_ok_q && !hit_q && !full) begin
              count_q <= count_q + CNT_W'(1);
            end
          end
          OP_DECODE: begin
            if (hit_q || (key_len_q >= LEN_W'(LEN_LIMIT))) begin
              prefix_bits_q <= '0;
              prefix_len_q  <= '0;
            end else begin
              prefix_bits_q <= key_code_q;
              prefix_len_q  <= key_len_q;
            end
          end
          default: begin
            count_q <= count_q;
          end
        endcase
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_sym_q;
  assign m_tuser_o  = STATUS_W'(out_status_q);

endmodule

`default_nettype wire

>>> bench/prefix_code_table_decoder_checker.sv
// checker for the prefix-code table decoder: predicts each result and compares it
module prefix_code_table_decoder_checker
  import pctd_pkg::*;
#(
  parameter int TABLE_ENTRIES = TBL_ENTRIES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_ready_i,
  input  wire logic [IN_DATA_W-1:0]  in_data_i,
  input  wire logic [OP_W-1:0]       in_user_i,
  input  wire logic                  out_valid_i,
  input  wire logic                  out_ready_i,
  input  wire logic [OUT_DATA_W-1:0] out_data_i,
  input  wire logic [STATUS_W-1:0]   out_user_i,
  output int                         pending_o,
  output int                         errors_o
);

  typedef struct packed {
    status_e          status;
    logic [SYM_W-1:0] sym;
  } decode_result_t;

  logic [CODE_W-1:0] book_code [TABLE_ENTRIES];
  logic [LEN_W-1:0]  book_len  [TABLE_ENTRIES];
  logic [SYM_W-1:0]  book_sym  [TABLE_ENTRIES];
  int unsigned       book_fill;
  logic [CODE_W-1:0] prefix_bits;
  logic [LEN_W-1:0]  prefix_len;
  decode_result_t    due_results [$];

  initial errors_o = 0;

  function automatic logic [CODE_W-1:0] used_bits(input logic [LEN_W-1:0] len);
    return (len >= CODE_W) ? {CODE_W{1'b1}} : ~({CODE_W{1'b1}} << len);
  endfunction

  function automatic int lookup_codeword(input logic [CODE_W-1:0] code,
                                         input logic [LEN_W-1:0] len);
    int i;
    for (i = 0; i < book_fill; i++) begin
      if (book_len[i] == len && book_code[i] == code) begin
        return i;
      end
    end
    return -1;
  endfunction

  // advances the codebook and prefix by one command and gives the result it causes
  function automatic decode_result_t decode_command(input logic [OP_W-1:0] op,
                                                    input logic [IN_DATA_W-1:0] data);
    decode_result_t    res;
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    int                idx;
    res  = '{status: ST_NONE, sym: '0};
    sym  = data[SYM_LSB +: SYM_W];
    len  = data[LEN_LSB +: LEN_W];
    code = data[CODE_LSB +: CODE_W] & used_bits(len);
    case (op)
      OP_CLEAR: begin
        book_fill   = 0;
        prefix_bits = '0;
        prefix_len  = '0;
      end
      OP_LOAD: begin
        if (len != '0 && len <= LEN_LIMIT) begin
          idx = lookup_codeword(code, len);
          if (idx >= 0) begin
            book_sym[idx] = sym;
          end else if (book_fill >= TABLE_ENTRIES) begin
            res.status = ST_FULL;
          end else begin
            book_code[book_fill] = code;
            book_len[book_fill]  = len;
            book_sym[book_fill]  = sym;
            book_fill++;
          end
        end
      end
      OP_DECODE: begin
        prefix_bits = {prefix_bits[CODE_W-2:0], data[BIT_POS]};
        prefix_len  = prefix_len + 1'b1;
        idx = lookup_codeword(prefix_bits & used_bits(prefix_len), prefix_len);
        if (idx >= 0) begin
          res.status  = ST_EMIT;
          res.sym     = book_sym[idx];
          prefix_bits = '0;
          prefix_len  = '0;
        end else if (prefix_len >= LEN_LIMIT) begin
          res.status  = ST_LONG;
          prefix_bits = '0;
          prefix_len  = '0;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    decode_result_t want;
    if (!rst_ni) begin
      book_fill   = 0;
      prefix_bits = '0;
      prefix_len  = '0;
      due_results.delete();
      pending_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        due_results.push_back(decode_command(in_user_i, in_data_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result transfer with none due: status %0d symbol %02h",
                                    out_user_i, out_data_i));
        end else begin
          want = due_results.pop_front();
          if (out_user_i !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %s", out_user_i,
                                      want.status.name()));
          end
          if (out_data_i !== want.sym) begin
            report_mismatch($sformatf("symbol %02h, expected %02h", out_data_i, want.sym));
          end
        end
      end
      pending_o <= due_results.size();
    end
  end

endmodule

>>> bench/prefix_code_table_decoder_tb.sv
// stimulus and verdict for the prefix-code table decoder
module prefix_code_table_decoder_tb;
  import pctd_pkg::*;

  localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;
  localparam int SETTLE_CYCLES = TBL_ENTRIES_DEF + 40;
  localparam int PHASE_CMDS    = 80;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic [OP_W-1:0]       s_axis_tuser_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic [STATUS_W-1:0]   m_axis_tuser_o;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int cmd_count = 0;
  int pending;
  int mismatches;

  // codes held by the full table, kept to decode them afterwards
  logic [CODE_W-1:0] full_code [TBL_ENTRIES_DEF];

  always #5 clk_i = ~clk_i;

  prefix_code_table_decoder uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  prefix_code_table_decoder_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_i  (s_axis_tready_o),
    .in_data_i   (s_axis_tdata_i),
    .in_user_i   (s_axis_tuser_i),
    .out_valid_i (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_i  (m_axis_tdata_o),
    .out_user_i  (m_axis_tuser_o),
    .pending_o   (pending),
    .errors_o    (mismatches)
  );

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                          input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len,
                          input logic code_bit);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {2'b00, code_bit, len, code, sym};
    @(posedge clk_i);
    while (!s_axis_tready_o) begin
      @(posedge clk_i);
    end
    // commands the block ignores do not count
    if (op == OP_CLEAR || op == OP_DECODE || (op == OP_LOAD && len != '0 && len <= LEN_LIMIT)) begin
      cmd_count++;
    end
  endtask

  task automatic clear_table();
    send_cmd(OP_CLEAR, SYM_W'($urandom), CODE_W'($urandom), LEN_W'($urandom_range(0, 31)),
             1'($urandom_range(0, 1)));
  endtask

  task automatic load_entry(input logic [SYM_W-1:0] sym, input logic [CODE_W-1:0] code,
                            input logic [LEN_W-1:0] len);
    send_cmd(OP_LOAD, sym, code, len, 1'($urandom_range(0, 1)));
  endtask

  task automatic decode_bit(input logic code_bit);
    send_cmd(OP_DECODE, SYM_W'($urandom), CODE_W'($urandom), LEN_W'($urandom_range(0, 31)),
             code_bit);
  endtask

  task automatic send_codeword(input logic [CODE_W-1:0] code, input int len);
    int i;
    for (i = len - 1; i >= 0; i--) begin
      decode_bit(code[i]);
    end
  endtask

  // no new transfer until every result due has come back
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (pending != 0);
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct);
    logic [CODE_W-1:0] leaf_code [24];
    logic [LEN_W-1:0]  leaf_len  [24];
    logic [OP_W-1:0]   op;
    int leaves, want_leaves, depth_cap, pick, tries, n, k, bitpos, first;
    bit drop_some;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    first = cmd_count;
    while (cmd_count - first < PHASE_CMDS) begin
      if ($urandom_range(0, 9) < 7) begin
        // grow a complete prefix code by splitting random leaves
        leaves       = 1;
        leaf_code[0] = '0;
        leaf_len[0]  = '0;
        want_leaves  = $urandom_range(2, 24);
        depth_cap    = ($urandom_range(0, 3) == 0) ? LEN_LIMIT : 6;
        tries        = 0;
        while (leaves < want_leaves && tries < 200) begin
          pick = $urandom_range(0, leaves - 1);
          if (leaf_len[pick] < depth_cap) begin
            leaf_code[leaves] = {leaf_code[pick][CODE_W-2:0], 1'b1};
            leaf_len[leaves]  = leaf_len[pick] + 1'b1;
            leaf_code[pick]   = {leaf_code[pick][CODE_W-2:0], 1'b0};
            leaf_len[pick]    = leaf_len[pick] + 1'b1;
            leaves++;
          end
          tries++;
        end
        // missing leaves leave holes in the code, so prefixes can run too long
        drop_some = ($urandom_range(0, 9) < 3);
        clear_table();
        for (k = 0; k < leaves; k++) begin
          if (!drop_some || $urandom_range(0, 4) != 0) begin
            load_entry(SYM_W'($urandom), leaf_code[k] |
                       ($urandom_range(0, 1) ? CODE_W'($urandom) << leaf_len[k] : '0),
                       leaf_len[k]);
          end
        end
        repeat ($urandom_range(1, 12)) begin
          pick = $urandom_range(0, leaves - 1);
          for (bitpos = int'(leaf_len[pick]) - 1; bitpos >= 0; bitpos--) begin
            decode_bit(leaf_code[pick][bitpos]);
            if ($urandom_range(0, 19) == 0) begin
              n = $urandom_range(0, leaves - 1);
              load_entry(SYM_W'($urandom), leaf_code[n], leaf_len[n]);
            end
          end
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          pick = $urandom_range(0, 9);
          if (pick == 0) begin
            op = OP_CLEAR;
          end else if (pick < 4) begin
            op = OP_LOAD;
          end else if (pick < 9) begin
            op = OP_DECODE;
          end else begin
            op = OP_UNDEF;
          end
          send_cmd(op, SYM_W'($urandom), CODE_W'($urandom), LEN_W'($urandom_range(0, 31)),
                   1'($urandom_range(0, 1)));
        end
      end
    end
    drain();
  endtask

  initial begin
    int i, pick;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    decode_bit(1'b1);
    clear_table();
    load_entry(8'h11, 16'h0001, 5'd0);
    load_entry(8'h22, 16'h0001, 5'd17);
    load_entry(8'h33, 16'hFFFF, 5'd31);
    load_entry(8'hFF, 16'hFFFF, 5'd16);
    load_entry(8'h00, 16'h0000, 5'd1);
    // bits above the length must be masked off
    load_entry(8'hA5, 16'hFFFE, 5'd2);
    send_cmd(OP_UNDEF, 8'hFF, 16'hFFFF, 5'd31, 1'b1);
    decode_bit(1'b0);
    send_codeword(16'h0002, 2);
    load_entry(8'h5A, 16'h0002, 5'd2);
    decode_bit(1'b1);
    load_entry(8'h3C, 16'h0007, 5'd3);
    decode_bit(1'b0);
    send_codeword(16'h0007, 3);
    drain();

    run_phase(12, 81);
    run_phase(81, 12);
    run_phase(0, 0);

    // fill every slot with distinct full-length codes
    clear_table();
    for (i = 0; i < TBL_ENTRIES_DEF; i++) begin
      full_code[i] = {8'($urandom), 8'(i)};
      load_entry(SYM_W'($urandom), full_code[i], LEN_W'(LEN_LIMIT));
    end
    pick = $urandom_range(0, TBL_ENTRIES_DEF - 1);
    load_entry(SYM_W'($urandom), full_code[pick] ^ 16'h0100, LEN_W'(LEN_LIMIT));
    load_entry(SYM_W'($urandom), 16'h0005, 5'd3);
    load_entry(SYM_W'($urandom), 16'h0005, 5'd0);
    load_entry(SYM_W'($urandom), full_code[pick], LEN_W'(LEN_LIMIT));
    send_codeword(full_code[pick], LEN_LIMIT);
    repeat (3) begin
      send_codeword(full_code[$urandom_range(0, TBL_ENTRIES_DEF - 1)], LEN_LIMIT);
    end
    send_codeword(full_code[pick] ^ 16'h0100, LEN_LIMIT);
    clear_table();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS prefix_code_table_decoder");
    end else begin
      $display("FAIL prefix_code_table_decoder");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("FAIL prefix_code_table_decoder");
    $finish;
  end

endmodule

>>> prefix_code_table_decoder.f
rtl/core/pctd_pkg.sv
rtl/core/pctd_ctrl.sv
rtl/core/pctd_dp.sv
rtl/core/prefix_code_table_decoder.sv
bench/prefix_code_table_decoder_checker.sv
bench/prefix_code_table_decoder_tb.sv
